>>> design/ftg_pkg.sv
// Shared constants and types for the flat-top Gaussian edge weight pipeline.
// Holds the exp(-2^(k-16)) table, register index codes and lane bundles.
// No dependencies.
package ftg_pkg;

    localparam int EXP_BITS     = 20;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [32:0] FLUSH_T = 33'd327680;
    localparam logic [31:0] ACC_ONE = 32'h8000_0000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ACTIVE_DIMS = 3'd0,
        REG_LOWER       = 3'd1,
        REG_UPPER       = 3'd2,
        REG_ISIG_LOW    = 3'd3,
        REG_ISIG_HIGH   = 3'd4
    } cfg_reg_t;

    // Q0.31 entries of exp(-2^(k-16)) for each bit k of the Q16 argument.
    localparam logic [30:0] EXP_TBL [EXP_BITS] = '{
        31'd2147450880, 31'd2147418113, 31'd2147352580, 31'd2147221520,
        31'd2146959424, 31'd2146435328, 31'd2145387520, 31'd2143293437,
        31'd2139111403, 31'd2130771798, 31'd2114190000, 31'd2081412522,
        31'd2017374191, 31'd1895147668, 31'd1672461947, 31'd1302514674,
        31'd790015084,  31'd290630308,  31'd39332535,   31'd720400
    };

    typedef struct packed {
        logic                one;
        logic                zero;
        logic [EXP_BITS-1:0] a;
        logic [31:0]         acc;
    } exp_lane_t;

endpackage

>>> design/flat_top_gaussian_edge_weight.sv
// Flat-top weight with Gaussian tapered edges, fully pipelined.
// Depends on ftg_pkg.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   config  | cfg_we, cfg_index, cfg_data           | in
//   point   | in_valid, in_stall, coord_0..coord_3  | in (in_stall is out)
//   result  | out_valid, out_stall, weight          | out (out_stall is in)
//
// One point enters per cycle while no stalled result holds the pipeline.
// The depth is set by the 20 exp multiply stages plus one multiply per dimension.
// Reset clears the valid bits and loads the register reset values.
// A stalled result holds the whole pipeline; in_stall rises only then.
module flat_top_gaussian_edge_weight #(
    parameter int MAX_DIMS   = 4,
    parameter int COORD_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ftg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [63:0]                       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [15:0]                coord_0,
    input  logic signed [15:0]                coord_1,
    input  logic signed [15:0]                coord_2,
    input  logic signed [15:0]                coord_3,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [16:0]                       weight
);
    import ftg_pkg::*;

    localparam int NST = 23 + MAX_DIMS;

    logic [2:0]  active_dims_reg;
    logic [63:0] lower_reg;
    logic [63:0] upper_reg;
    logic [63:0] isig_low_reg;
    logic [63:0] isig_high_reg;

    logic [NST-1:0] vld_reg;
    logic           en;
    logic [15:0]    coord_w [4];

    logic [32:0] s1_t_reg    [MAX_DIMS];
    logic        s1_one_reg  [MAX_DIMS];
    logic        s1_zero_reg [MAX_DIMS];
    exp_lane_t   exp_reg     [EXP_BITS+1][MAX_DIMS];
    logic [16:0] fac_reg     [MAX_DIMS][MAX_DIMS];
    logic [16:0] w_reg       [MAX_DIMS];

    assign coord_w[0] = coord_0;
    assign coord_w[1] = coord_1;
    assign coord_w[2] = coord_2;
    assign coord_w[3] = coord_3;

    assign en        = !(vld_reg[NST-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[NST-1];
    assign weight    = w_reg[MAX_DIMS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_dims_reg <= 3'd1;
            lower_reg       <= '0;
            upper_reg       <= '0;
            isig_low_reg    <= '0;
            isig_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_DIMS: active_dims_reg <= cfg_data[2:0];
                REG_LOWER:       lower_reg       <= cfg_data;
                REG_UPPER:       upper_reg       <= cfg_data;
                REG_ISIG_LOW:    isig_low_reg    <= cfg_data;
                REG_ISIG_HIGH:   isig_high_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    for (genvar l = 0; l < MAX_DIMS; l++)
    begin : g_lane
        logic signed [COORD_BITS-1:0] xn, lon, hin;
        logic signed [17:0] x, lo, hi, dlo, dhi;
        logic [16:0] d;
        logic [15:0] s;
        logic        one_next, zero_next;
        logic        zero2;
        logic [37:0] sq;

        assign xn  = coord_w[l][COORD_BITS-1:0];
        assign lon = lower_reg[16*l +: COORD_BITS];
        assign hin = upper_reg[16*l +: COORD_BITS];
        assign x   = 18'(xn);
        assign lo  = 18'(lon);
        assign hi  = 18'(hin);
        assign dlo = lo - x;
        assign dhi = x - hi;

        // The below-lower test wins when the limits are crossed.
        always_comb
        begin
            one_next  = 1'b0;
            zero_next = 1'b0;
            d         = '0;
            s         = '0;
            if (3'(l) >= active_dims_reg)
            begin
                one_next = 1'b1;
            end
            else if (x < lo)
            begin
                d         = dlo[16:0];
                s         = isig_low_reg[16*l +: 16];
                zero_next = (s == 16'd0);
            end
            else if (x > hi)
            begin
                d         = dhi[16:0];
                s         = isig_high_reg[16*l +: 16];
                zero_next = (s == 16'd0);
            end
            else
            begin
                one_next = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s1_t_reg[l]    <= 33'(d) * 33'(s);
                s1_one_reg[l]  <= one_next;
                s1_zero_reg[l] <= zero_next;
            end
        end

        assign zero2 = s1_zero_reg[l] || (s1_t_reg[l] >= FLUSH_T);
        assign sq    = 38'(s1_t_reg[l][18:0]) * 38'(s1_t_reg[l][18:0]) + 38'd65536;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                exp_reg[0][l].one  <= s1_one_reg[l];
                exp_reg[0][l].zero <= zero2;
                exp_reg[0][l].a    <= sq[36:17];
                exp_reg[0][l].acc  <= ACC_ONE;
            end
        end

        // One table multiply per stage, taken only when that argument bit is set.
        for (genvar k = 0; k < EXP_BITS; k++)
        begin : g_exp
            logic [62:0] prod;
            assign prod = 63'(exp_reg[k][l].acc) * 63'(EXP_TBL[k]) + 63'h4000_0000;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    exp_reg[k+1][l].one  <= exp_reg[k][l].one;
                    exp_reg[k+1][l].zero <= exp_reg[k][l].zero;
                    exp_reg[k+1][l].a    <= exp_reg[k][l].a;
                    exp_reg[k+1][l].acc  <= exp_reg[k][l].a[k] ? prod[62:31]
                                                                : exp_reg[k][l].acc;
                end
            end
        end

        logic [31:0] rnd;
        assign rnd = exp_reg[EXP_BITS][l].acc + 32'h0000_4000;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (exp_reg[EXP_BITS][l].one)
                    fac_reg[0][l] <= ONE_Q16;
                else if (exp_reg[EXP_BITS][l].zero)
                    fac_reg[0][l] <= '0;
                else
                    fac_reg[0][l] <= rnd[31:15];
            end
        end
    end

    for (genvar j = 0; j < MAX_DIMS; j++)
    begin : g_mul
        logic [16:0] w_in;
        logic [33:0] wp;
        if (j == 0)
        begin : g_first
            assign w_in = ONE_Q16;
        end
        else
        begin : g_next
            assign w_in = w_reg[j-1];
        end
        assign wp = 34'(w_in) * 34'(fac_reg[j][j]) + 34'd32768;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                w_reg[j] <= wp[32:16];
            end
        end

        if (j + 1 < MAX_DIMS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    fac_reg[j+1] <= fac_reg[j];
                end
            end
        end
    end

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (weight <= ONE_Q16))
        else $error("weight above one");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted item lost at pipeline entry");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for flat_top_gaussian_edge_weight.
// Predicts each weight in fixed point from the register settings and compares
// every result in order; depends on ftg_pkg and the block itself.
`timescale 1ns / 1ps

module testbench;
    import ftg_pkg::*;

    localparam int LATENCY = 27;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    cfg_reg_t           cfg_index;
    logic [63:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] coord_0;
    logic signed [15:0] coord_1;
    logic signed [15:0] coord_2;
    logic signed [15:0] coord_3;
    logic               out_valid;
    logic               out_stall;
    logic [16:0]        weight;

    // Testbench copy of the block's registers.
    logic [2:0]  dims_q;
    logic [63:0] lower_q;
    logic [63:0] upper_q;
    logic [63:0] isig_lo_q;
    logic [63:0] isig_hi_q;

    logic [16:0] weight_queue[$];
    int          error_count;
    int          hold_cycles;
    bit          quiet_mode;
    logic [31:0] exp_entry[20];

    flat_top_gaussian_edge_weight u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .coord_0   (coord_0),
        .coord_1   (coord_1),
        .coord_2   (coord_2),
        .coord_3   (coord_3),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .weight    (weight)
    );

    initial
    begin
        clk = 1'b0;
        exp_entry = '{
            32'd2147450880, 32'd2147418113, 32'd2147352580, 32'd2147221520,
            32'd2146959424, 32'd2146435328, 32'd2145387520, 32'd2143293437,
            32'd2139111403, 32'd2130771798, 32'd2114190000, 32'd2081412522,
            32'd2017374191, 32'd1895147668, 32'd1672461947, 32'd1302514674,
            32'd790015084,  32'd290630308,  32'd39332535,   32'd720400
        };
    end

    always #5 clk = ~clk;

    function automatic logic [16:0] edge_gain(input logic [15:0] gap,
                                              input logic [15:0] isig);
        logic [63:0] t;
        logic [63:0] a;
        logic [63:0] acc;
        acc = 64'd1 << 31;
        if (isig == 16'd0)
            return 17'd0;
        t = 64'(gap) * 64'(isig);
        if (t >= 64'd327680)
            return 17'd0;
        a = (t * t + 64'd65536) >> 17;
        for (int k = 0; k < 20; k++)
            if (a[k])
                acc = (acc * 64'(exp_entry[k]) + (64'd1 << 30)) >> 31;
        return 17'((acc + 64'd16384) >> 15);
    endfunction

    function automatic logic [16:0] point_weight(input logic [15:0] pt[4]);
        logic [63:0]        w;
        int                 n;
        logic signed [16:0] x;
        logic signed [16:0] lo;
        logic signed [16:0] hi;
        logic [16:0]        f;
        w = 64'd65536;
        n = (dims_q > 3'd4) ? 4 : int'(dims_q);
        for (int k = 0; k < n; k++)
        begin
            x  = 17'(signed'(pt[k]));
            lo = 17'(signed'(lower_q[16*k +: 16]));
            hi = 17'(signed'(upper_q[16*k +: 16]));
            if (x < lo)
                f = edge_gain(16'(lo - x), isig_lo_q[16*k +: 16]);
            else if (x > hi)
                f = edge_gain(16'(x - hi), isig_hi_q[16*k +: 16]);
            else
                f = 17'd65536;
            w = (w * 64'(f) + 64'd32768) >> 16;
        end
        return w[16:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ACTIVE_DIMS: dims_q    = value[2:0];
            REG_LOWER:       lower_q   = value;
            REG_UPPER:       upper_q   = value;
            REG_ISIG_LOW:    isig_lo_q = value;
            REG_ISIG_HIGH:   isig_hi_q = value;
            default: ;
        endcase
    endtask

    // Valid stays high after an accepted item so that back-to-back items
    // need no gap; drain() drops it when the sender goes quiet.
    task automatic send_point(input logic [15:0] c0, input logic [15:0] c1,
                              input logic [15:0] c2, input logic [15:0] c3);
        logic [15:0] pt[4];
        pt = '{c0, c1, c2, c3};
        while (!quiet_mode && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coord_0  <= c0;
        coord_1  <= c1;
        coord_2  <= c2;
        coord_3  <= c3;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        weight_queue.push_back(point_weight(pt));
    endtask

    // Wait for every result, then let the pipeline drain before a write.
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (weight_queue.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic send_random(input int count, input bit near_edges);
        logic [15:0] c[4];
        for (int i = 0; i < count; i++)
        begin
            for (int k = 0; k < 4; k++)
                if (near_edges && $urandom_range(3) != 0)
                    c[k] = (($urandom_range(1) != 0) ? lower_q[16*k +: 16]
                            : upper_q[16*k +: 16]) + 16'($urandom_range(1200)) - 16'd600;
                else
                    c[k] = 16'($urandom);
            send_point(c[0], c[1], c[2], c[3]);
        end
    endtask

    task automatic test_reset_values();
        send_point(16'h0000, 16'h1234, 16'h8000, 16'h7FFF);
        send_point(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_point(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        drain();
    endtask

    task automatic test_directed_edges();
        write_reg(REG_ACTIVE_DIMS, 64'd4);
        write_reg(REG_LOWER, {16'h8000, 16'hFF00, 16'h0000, 16'hFE00});
        write_reg(REG_UPPER, {16'h7FFF, 16'h0100, 16'h0200, 16'h0200});
        write_reg(REG_ISIG_LOW, {16'hFFFF, 16'h0100, 16'h0000, 16'h0080});
        write_reg(REG_ISIG_HIGH, {16'h0001, 16'h0040, 16'h0100, 16'hFFFF});
        send_point(16'h0000, 16'h0100, 16'h0000, 16'h0000);
        send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_point(16'hFD00, 16'hFF80, 16'h0280, 16'h0000);
        send_point(16'hF000, 16'h0300, 16'h0500, 16'h1000);
        send_point(16'h0201, 16'hFEFF, 16'hFFFF, 16'h0101);
        send_point(16'hFDFF, 16'h0000, 16'h0000, 16'h0000);
        drain();
        // Lower limit above upper limit, then dimension counts of zero and seven.
        write_reg(REG_LOWER, {4{16'h0300}});
        write_reg(REG_UPPER, {4{16'hFD00}});
        send_point(16'h0000, 16'h0400, 16'hFC00, 16'h0300);
        send_point(16'h02FF, 16'hFD01, 16'h0000, 16'h0000);
        drain();
        write_reg(REG_ACTIVE_DIMS, 64'd0);
        send_point(16'h8000, 16'h7FFF, 16'h0000, 16'h5555);
        drain();
        write_reg(REG_ACTIVE_DIMS, 64'd7);
        send_point(16'h8000, 16'h7FFF, 16'h0000, 16'h5555);
        drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_ACTIVE_DIMS, 64'($urandom_range(7)));
            write_reg(REG_LOWER, {32'($urandom), 32'($urandom)} & 64'h0FFF_0FFF_0FFF_0FFF
                      ^ 64'hF800_F800_F800_F800);
            write_reg(REG_UPPER, {32'($urandom), 32'($urandom)} & 64'h0FFF_0FFF_0FFF_0FFF);
            write_reg(REG_ISIG_LOW, {32'($urandom), 32'($urandom)} & 64'h03FF_03FF_03FF_03FF);
            write_reg(REG_ISIG_HIGH, {32'($urandom), 32'($urandom)});
            quiet_mode = (phase == 2);
            send_random(200, 1'b1);
            send_random(40, 1'b0);
            drain();
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_backpressure();
        write_reg(REG_ACTIVE_DIMS, 64'd4);
        write_reg(REG_ISIG_LOW, {4{16'h0100}});
        write_reg(REG_ISIG_HIGH, {4{16'h0200}});
        hold_cycles = 80;
        send_random(120, 1'b1);
        drain();
    endtask

    // Receiver: random stalls, plus a long hold when hold_cycles is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            out_stall <= !quiet_mode && ($urandom_range(99) < 28);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (weight_queue.size() == 0)
                report_mismatch($sformatf("unexpected weight %0d", weight));
            else
            begin
                logic [16:0] want;
                want = weight_queue.pop_front();
                if (weight !== want)
                    report_mismatch($sformatf("weight %0d, expected %0d", weight, want));
            end
        end
    end

    initial
    begin
        #20ms;
        $display("flat_top_gaussian_edge_weight regression: fail");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_ACTIVE_DIMS;
        cfg_data    = '0;
        in_valid    = 1'b0;
        coord_0     = '0;
        coord_1     = '0;
        coord_2     = '0;
        coord_3     = '0;
        error_count = 0;
        hold_cycles = 0;
        quiet_mode  = 1'b0;
        dims_q      = 3'd1;
        lower_q     = '0;
        upper_q     = '0;
        isig_lo_q   = '0;
        isig_hi_q   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed_edges();
        test_random_settings();
        test_backpressure();
        if (weight_queue.size() != 0)
            report_mismatch($sformatf("%0d weights never arrived", weight_queue.size()));
        if (error_count == 0)
            $display("flat_top_gaussian_edge_weight regression: pass");
        else
            $display("flat_top_gaussian_edge_weight regression: fail");
        $finish;
    end
endmodule
